// ===== design/rc4sc_pkg.sv =====
package rc4sc_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned PERM_DEPTH = 256;

	typedef struct packed {
		logic              action;
		logic [BYTE_W-1:0] byte_value;
		logic              last_flag;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              out_last;
	} out_item_t;

	localparam logic ACT_KEY  = 1'b0;
	localparam logic ACT_DATA = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_KS_RD_I,
		ST_KS_RD_J,
		ST_KS_WR_I,
		ST_KS_WR_J,
		ST_SC_START,
		ST_SC_RD_K,
		ST_SC_RD_J,
		ST_SC_WR_K,
		ST_SC_WR_J
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_KS_RD_I,
		OP_KS_RD_J,
		OP_KS_WR_I,
		OP_KS_WR_J,
		OP_SC_START,
		OP_SC_RD_K,
		OP_SC_RD_J,
		OP_SC_WR_K,
		OP_SC_WR_J
	} op_t;

	typedef struct packed {
		op_t  op;
		logic take;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic sched_done;
	} dp_status_t;

endpackage

// ===== design/rc4_stream_cipher_unit.sv =====
// data byte: ST_KS_RD_I, ST_KS_RD_J, ST_KS_WR_I, then ST_KS_WR_J loads the result when the
// output register is free; next byte only back in idle, set by three dependent reads and two
// writes on the permutation memory; key byte: input stays ready; last key byte: start state,
// then 256 steps of four permutation memory accesses each before the next transfer
// reset: permutation reads as identity (per-entry valid bits), i, j and key length zero,
// key store contents undefined
module rc4_stream_cipher_unit #(
	parameter int unsigned KEY_MAX_BYTES = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  rc4sc_pkg::in_item_t  item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output rc4sc_pkg::out_item_t result
);

	rc4sc_pkg::ctrl_cmd_t  cmd;
	rc4sc_pkg::dp_status_t status;

	rc4sc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item         (item),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.cmd          (cmd),
		.status       (status)
	);

	rc4sc_datapath #(
		.KEY_MAX_BYTES (KEY_MAX_BYTES)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.status (status),
		.result (result)
	);

`ifndef SYNTHESIS
	a_busy_after_data: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready && item.action == rc4sc_pkg::ACT_DATA) |=> !item_ready)
		else $error("input taken while a data byte is in progress");

	a_busy_after_last_key: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready && item.action == rc4sc_pkg::ACT_KEY && item.last_flag)
		|=> !item_ready)
		else $error("input taken while the key schedule runs");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> !$past(item_ready))
		else $error("result appeared without a data byte in progress");
`endif

endmodule

// ===== design/rc4sc_ctrl.sv =====
module rc4sc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	input  rc4sc_pkg::in_item_t   item,
	output logic                  item_ready,
	output logic                  result_valid,
	input  logic                  result_ready,
	output rc4sc_pkg::ctrl_cmd_t  cmd,
	input  rc4sc_pkg::dp_status_t status
);

	rc4sc_pkg::state_t state_q, state_d;
	logic              out_valid_q;
	logic              out_free;

	assign out_free     = !out_valid_q || result_ready;
	assign item_ready   = (state_q == rc4sc_pkg::ST_IDLE);
	assign result_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rc4sc_pkg::ST_IDLE: begin
				if (item_valid) begin
					if (item.action == rc4sc_pkg::ACT_DATA)
						state_d = rc4sc_pkg::ST_KS_RD_I;
					else if (item.last_flag)
						state_d = rc4sc_pkg::ST_SC_START;
				end
			end
			rc4sc_pkg::ST_KS_RD_I:  state_d = rc4sc_pkg::ST_KS_RD_J;
			rc4sc_pkg::ST_KS_RD_J:  state_d = rc4sc_pkg::ST_KS_WR_I;
			rc4sc_pkg::ST_KS_WR_I:  state_d = rc4sc_pkg::ST_KS_WR_J;
			// hold here until the output register is free
			rc4sc_pkg::ST_KS_WR_J: begin
				if (out_free)
					state_d = rc4sc_pkg::ST_IDLE;
			end
			rc4sc_pkg::ST_SC_START: state_d = rc4sc_pkg::ST_SC_RD_K;
			rc4sc_pkg::ST_SC_RD_K:  state_d = rc4sc_pkg::ST_SC_RD_J;
			rc4sc_pkg::ST_SC_RD_J:  state_d = rc4sc_pkg::ST_SC_WR_K;
			rc4sc_pkg::ST_SC_WR_K:  state_d = rc4sc_pkg::ST_SC_WR_J;
			rc4sc_pkg::ST_SC_WR_J: begin
				state_d = status.sched_done ? rc4sc_pkg::ST_IDLE : rc4sc_pkg::ST_SC_RD_K;
			end
			default: state_d = rc4sc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.take     = 1'b0;
		cmd.out_load = 1'b0;
		cmd.op       = rc4sc_pkg::OP_NONE;
		unique case (state_q)
			rc4sc_pkg::ST_IDLE: cmd.take = item_valid;
			rc4sc_pkg::ST_KS_RD_I:  cmd.op = rc4sc_pkg::OP_KS_RD_I;
			rc4sc_pkg::ST_KS_RD_J:  cmd.op = rc4sc_pkg::OP_KS_RD_J;
			rc4sc_pkg::ST_KS_WR_I:  cmd.op = rc4sc_pkg::OP_KS_WR_I;
			rc4sc_pkg::ST_KS_WR_J: begin
				cmd.op       = rc4sc_pkg::OP_KS_WR_J;
				cmd.out_load = out_free;
			end
			rc4sc_pkg::ST_SC_START: cmd.op = rc4sc_pkg::OP_SC_START;
			rc4sc_pkg::ST_SC_RD_K:  cmd.op = rc4sc_pkg::OP_SC_RD_K;
			rc4sc_pkg::ST_SC_RD_J:  cmd.op = rc4sc_pkg::OP_SC_RD_J;
			rc4sc_pkg::ST_SC_WR_K:  cmd.op = rc4sc_pkg::OP_SC_WR_K;
			rc4sc_pkg::ST_SC_WR_J:  cmd.op = rc4sc_pkg::OP_SC_WR_J;
			default: cmd.op = rc4sc_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rc4sc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (result_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== design/rc4sc_datapath.sv =====
module rc4sc_datapath #(
	parameter int unsigned KEY_MAX_BYTES = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rc4sc_pkg::in_item_t   item,
	input  rc4sc_pkg::ctrl_cmd_t  cmd,
	output rc4sc_pkg::dp_status_t status,
	output rc4sc_pkg::out_item_t  result
);

	localparam int unsigned KAW = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;
	localparam int unsigned LW  = $clog2(KEY_MAX_BYTES + 1);
	localparam int unsigned BW  = rc4sc_pkg::BYTE_W;
	localparam int unsigned PD  = rc4sc_pkg::PERM_DEPTH;

	// permutation memory, entries not yet written read as their own index
	logic [BW-1:0] perm_mem [PD];
	logic [PD-1:0] perm_vld_q;
	logic [BW-1:0] perm_rd_q;
	logic [BW-1:0] perm_raddr;
	logic          perm_we;
	logic [BW-1:0] perm_waddr;
	logic [BW-1:0] perm_wdata;

	logic [BW-1:0] key_mem [KEY_MAX_BYTES];
	logic [BW-1:0] key_rd_q;
	logic          key_we;
	logic [LW-1:0] key_len_q;
	logic [KAW-1:0] kidx_q;
	logic [LW-1:0] kidx_next;

	logic [BW-1:0] i_q, j_q, k_q;
	logic [BW-1:0] si_q, sj_q;
	logic [BW-1:0] data_q;
	logic          last_q;
	logic [BW-1:0] kb;
	logic [BW-1:0] j_sched;
	logic [BW-1:0] j_gen;
	logic [BW-1:0] t_idx;
	logic [BW-1:0] ks_byte;
	rc4sc_pkg::out_item_t result_q;

	assign result = result_q;

	assign key_we    = cmd.take && (item.action == rc4sc_pkg::ACT_KEY)
	                   && (key_len_q < LW'(KEY_MAX_BYTES));
	assign kidx_next = LW'(kidx_q) + LW'(1);
	assign kb        = (key_len_q == '0) ? '0 : key_rd_q;
	assign j_sched   = BW'(j_q + perm_rd_q + kb);
	assign j_gen     = BW'(j_q + perm_rd_q);
	assign t_idx     = BW'(si_q + sj_q);

	assign status.sched_done = (cmd.op == rc4sc_pkg::OP_SC_WR_J) && (k_q == BW'(PD - 1));

	// the read of S[t] ran alongside the write of S[i]; S[j] is written last
	always_comb begin
		priority if (t_idx == j_q)
			ks_byte = si_q;
		else if (t_idx == i_q)
			ks_byte = sj_q;
		else
			ks_byte = perm_rd_q;
	end

	always_comb begin
		perm_raddr = k_q;
		perm_we    = 1'b0;
		perm_waddr = i_q;
		perm_wdata = sj_q;
		unique case (cmd.op)
			rc4sc_pkg::OP_KS_RD_I: perm_raddr = BW'(i_q + BW'(1));
			rc4sc_pkg::OP_KS_RD_J: perm_raddr = j_gen;
			rc4sc_pkg::OP_KS_WR_I: begin
				perm_raddr = BW'(si_q + perm_rd_q);
				perm_we    = 1'b1;
				perm_waddr = i_q;
				perm_wdata = perm_rd_q;
			end
			rc4sc_pkg::OP_KS_WR_J: begin
				perm_raddr = t_idx;
				perm_we    = 1'b1;
				perm_waddr = j_q;
				perm_wdata = si_q;
			end
			rc4sc_pkg::OP_SC_RD_J: perm_raddr = j_sched;
			rc4sc_pkg::OP_SC_WR_K: begin
				perm_we    = 1'b1;
				perm_waddr = k_q;
				perm_wdata = perm_rd_q;
			end
			rc4sc_pkg::OP_SC_WR_J: begin
				perm_we    = 1'b1;
				perm_waddr = j_q;
				perm_wdata = si_q;
			end
			default: perm_raddr = k_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (perm_we)
			perm_mem[perm_waddr] <= perm_wdata;
		perm_rd_q <= perm_vld_q[perm_raddr] ? perm_mem[perm_raddr] : perm_raddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			perm_vld_q <= '0;
		end else if (cmd.op == rc4sc_pkg::OP_SC_START) begin
			perm_vld_q <= '0;
		end else if (perm_we) begin
			perm_vld_q[perm_waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (key_we)
			key_mem[key_len_q[KAW-1:0]] <= item.byte_value;
		key_rd_q <= key_mem[kidx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_len_q <= '0;
			kidx_q    <= '0;
			i_q       <= '0;
			j_q       <= '0;
			k_q       <= '0;
		end else begin
			if (key_we)
				key_len_q <= key_len_q + LW'(1);
			unique case (cmd.op)
				rc4sc_pkg::OP_KS_RD_I: i_q <= BW'(i_q + BW'(1));
				rc4sc_pkg::OP_KS_RD_J: j_q <= j_gen;
				rc4sc_pkg::OP_SC_START: begin
					k_q    <= '0;
					j_q    <= '0;
					kidx_q <= '0;
				end
				rc4sc_pkg::OP_SC_RD_K: begin
					// key index wraps at the stored length
					if (kidx_next >= key_len_q)
						kidx_q <= '0;
					else
						kidx_q <= kidx_next[KAW-1:0];
				end
				rc4sc_pkg::OP_SC_RD_J: j_q <= j_sched;
				rc4sc_pkg::OP_SC_WR_J: begin
					k_q <= BW'(k_q + BW'(1));
					if (status.sched_done) begin
						i_q       <= '0;
						j_q       <= '0;
						key_len_q <= '0;
					end
				end
				default: k_q <= k_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			data_q <= item.byte_value;
			last_q <= item.last_flag;
		end
		if (cmd.op == rc4sc_pkg::OP_KS_RD_J || cmd.op == rc4sc_pkg::OP_SC_RD_J)
			si_q <= perm_rd_q;
		if (cmd.op == rc4sc_pkg::OP_KS_WR_I)
			sj_q <= perm_rd_q;
		if (cmd.out_load) begin
			result_q.out_byte <= data_q ^ ks_byte;
			result_q.out_last <= last_q;
		end
	end

endmodule
